/* sv/sse_pkg.sv */
package sse_pkg;

  // Default table sizes.
  localparam int unsigned SSE_MAX_OPERATIONS  = 64;
  localparam int unsigned SSE_MAX_MACHINES    = 8;
  localparam int unsigned SSE_MAX_JOBS        = 32;
  localparam int unsigned SSE_MAX_PRECEDENCES = 64;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_OBJECTIVE_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPERATION_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MACHINE_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JOB_COUNT        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRECEDENCE_COUNT = 3'd4;

  // Item operation codes.
  localparam logic [2:0] OP_ASSIGN    = 3'd0;
  localparam logic [2:0] OP_UNASSIGN  = 3'd1;
  localparam logic [2:0] OP_LOAD_TIME = 3'd2;
  localparam logic [2:0] OP_LOAD_OPER = 3'd3;
  localparam logic [2:0] OP_LOAD_JOB  = 3'd4;
  localparam logic [2:0] OP_LOAD_PREC = 3'd5;
  localparam logic [2:0] OP_EVALUATE  = 3'd6;

  // Objective modes.
  localparam logic [1:0] MODE_TARDINESS = 2'd1;
  localparam logic [1:0] MODE_FLOW      = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  item_index;
    logic [2:0]  machine_number;
    logic [15:0] time_value;
    logic [7:0]  job_weight_in;
    logic        flag_bit;
    logic [5:0]  ref_first;
    logic [5:0]  ref_second;
  } in_item_t;

  typedef struct packed {
    logic [31:0] objective_value;
    logic        is_feasible;
    logic [6:0]  assigned_total;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  last;
    logic        has_ops;
    logic [15:0] due;
    logic [7:0]  weight;
  } job_t;

  typedef struct packed {
    logic [5:0] first;
    logic [5:0] second;
  } prec_t;

  // Which walk drives the operation-info read ports.
  typedef enum logic [1:0] {
    PH_PAIR = 2'd0,
    PH_PREC = 2'd1,
    PH_JOB  = 2'd2
  } phase_e;

  typedef struct packed {
    logic   take;
    logic   init;
    logic   p1_chk;
    logic   p2_init;
    logic   p2_chk;
    logic   p3_init;
    logic   p3_chk;
    logic   p4_init;
    logic   p4_tard;
    logic   p4_mul;
    logic   p4_acc;
    logic   finish;
    phase_e phase;
  } sse_cmd_t;

  typedef struct packed {
    logic eval_op;
    logic op_done;
    logic pair_done;
    logic prec_done;
    logic job_done;
    logic use_jobs;
    logic out_busy;
  } sse_status_t;

endpackage

/* sv/sse_ram.sv */
module sse_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/sse_ctrl.sv */
module sse_ctrl import sse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  sse_status_t st_i,
  output sse_cmd_t    cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_P1_RD   = 15'b000000000000010,
    S_P1_LEN  = 15'b000000000000100,
    S_P1_CHK  = 15'b000000000001000,
    S_P2_RD   = 15'b000000000010000,
    S_P2_CHK  = 15'b000000000100000,
    S_P3_RD   = 15'b000000001000000,
    S_P3_INFO = 15'b000000010000000,
    S_P3_CHK  = 15'b000000100000000,
    S_P4_RD   = 15'b000001000000000,
    S_P4_INFO = 15'b000010000000000,
    S_P4_TARD = 15'b000100000000000,
    S_P4_MUL  = 15'b001000000000000,
    S_P4_ACC  = 15'b010000000000000,
    S_DONE    = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.phase = PH_PAIR;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.take = in_valid_i;
        if (in_valid_i && st_i.eval_op) begin
          cmd_o.init = 1'b1;
          state_d    = S_P1_RD;
        end
      end
      S_P1_RD: begin
        if (st_i.op_done) begin
          cmd_o.p2_init = 1'b1;
          state_d       = S_P2_RD;
        end else begin
          state_d = S_P1_LEN;
        end
      end
      S_P1_LEN: state_d = S_P1_CHK;
      S_P1_CHK: begin
        cmd_o.p1_chk = 1'b1;
        state_d      = S_P1_RD;
      end
      S_P2_RD: begin
        if (st_i.pair_done) begin
          cmd_o.p3_init = 1'b1;
          state_d       = S_P3_RD;
        end else begin
          state_d = S_P2_CHK;
        end
      end
      S_P2_CHK: begin
        cmd_o.p2_chk = 1'b1;
        state_d      = S_P2_RD;
      end
      S_P3_RD: begin
        cmd_o.phase = PH_PREC;
        if (st_i.prec_done) begin
          if (st_i.use_jobs) begin
            cmd_o.p4_init = 1'b1;
            state_d       = S_P4_RD;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          state_d = S_P3_INFO;
        end
      end
      S_P3_INFO: begin
        cmd_o.phase = PH_PREC;
        state_d     = S_P3_CHK;
      end
      S_P3_CHK: begin
        cmd_o.phase  = PH_PREC;
        cmd_o.p3_chk = 1'b1;
        state_d      = S_P3_RD;
      end
      S_P4_RD: begin
        cmd_o.phase = PH_JOB;
        state_d     = st_i.job_done ? S_DONE : S_P4_INFO;
      end
      S_P4_INFO: begin
        cmd_o.phase = PH_JOB;
        state_d     = S_P4_TARD;
      end
      S_P4_TARD: begin
        cmd_o.phase   = PH_JOB;
        cmd_o.p4_tard = 1'b1;
        state_d       = S_P4_MUL;
      end
      S_P4_MUL: begin
        cmd_o.phase  = PH_JOB;
        cmd_o.p4_mul = 1'b1;
        state_d      = S_P4_ACC;
      end
      S_P4_ACC: begin
        cmd_o.phase  = PH_JOB;
        cmd_o.p4_acc = 1'b1;
        state_d      = S_P4_RD;
      end
      S_DONE: begin
        if (!st_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/sse_datapath.sv */
module sse_datapath import sse_pkg::*; #(
  parameter int unsigned MAX_OPERATIONS  = SSE_MAX_OPERATIONS,
  parameter int unsigned MAX_MACHINES    = SSE_MAX_MACHINES,
  parameter int unsigned MAX_JOBS        = SSE_MAX_JOBS,
  parameter int unsigned MAX_PRECEDENCES = SSE_MAX_PRECEDENCES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  in_item_t              in_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  sse_cmd_t              cmd_i,
  output sse_status_t           st_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output out_item_t             out_data_o
);

  localparam int unsigned OW  = $clog2(MAX_OPERATIONS);
  localparam int unsigned OCW = $clog2(MAX_OPERATIONS + 1);
  localparam int unsigned MW  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int unsigned MCW = $clog2(MAX_MACHINES + 1);
  localparam int unsigned JW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned JCW = $clog2(MAX_JOBS + 1);
  localparam int unsigned PW  = (MAX_PRECEDENCES > 1) ? $clog2(MAX_PRECEDENCES) : 1;
  localparam int unsigned PCW = $clog2(MAX_PRECEDENCES + 1);
  localparam int unsigned LD  = MAX_OPERATIONS * MAX_MACHINES;
  localparam int unsigned LW  = $clog2(LD);
  localparam int unsigned MAXC = (MAX_OPERATIONS > MAX_JOBS) ?
    ((MAX_OPERATIONS > MAX_PRECEDENCES) ? MAX_OPERATIONS : MAX_PRECEDENCES) :
    ((MAX_JOBS > MAX_PRECEDENCES) ? MAX_JOBS : MAX_PRECEDENCES);
  localparam int unsigned CW  = $clog2(MAXC + 1);
  localparam int unsigned KW  = $clog2(MAX_OPERATIONS + 2);

  typedef struct packed {
    logic [MW-1:0] mach;
    logic [15:0]   start;
  } slot_t;

  typedef struct packed {
    logic        elig;
    logic [15:0] len;
  } len_t;

  typedef struct packed {
    logic [15:0]   start;
    logic [MW-1:0] mach;
    logic [16:0]   comp;
    logic          inelig;
    logic          lenzero;
  } info_t;

  function automatic logic [31:0] comp32(info_t f);
    comp32 = f.inelig ? 32'hFFFF_FFFF : 32'(f.comp);
  endfunction

  // Configuration registers.
  logic [1:0] mode_q;
  logic [6:0] op_cnt_q, prec_cnt_q;
  logic [3:0] mach_cnt_q;
  logic [5:0] job_cnt_q;

  logic [OCW-1:0] nops;
  logic [MCW-1:0] nmach;
  logic [JCW-1:0] njobs;
  logic [PCW-1:0] nprec;

  assign nops  = (32'(op_cnt_q) > 32'(MAX_OPERATIONS)) ? OCW'(MAX_OPERATIONS) : OCW'(op_cnt_q);
  assign nmach = (32'(mach_cnt_q) > 32'(MAX_MACHINES)) ? MCW'(MAX_MACHINES) : MCW'(mach_cnt_q);
  assign njobs = (32'(job_cnt_q) > 32'(MAX_JOBS)) ? JCW'(MAX_JOBS) : JCW'(job_cnt_q);
  assign nprec = (32'(prec_cnt_q) > 32'(MAX_PRECEDENCES)) ?
                 PCW'(MAX_PRECEDENCES) : PCW'(prec_cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= '0;
      op_cnt_q   <= '0;
      mach_cnt_q <= 4'd1;
      job_cnt_q  <= '0;
      prec_cnt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_OBJECTIVE_MODE:   mode_q     <= cfg_data_i[1:0];
        CFG_OPERATION_COUNT:  op_cnt_q   <= cfg_data_i;
        CFG_MACHINE_COUNT:    mach_cnt_q <= cfg_data_i[3:0];
        CFG_JOB_COUNT:        job_cnt_q  <= cfg_data_i[5:0];
        CFG_PRECEDENCE_COUNT: prec_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic use_jobs, flow_mode;
  assign use_jobs  = (mode_q == MODE_TARDINESS) || (mode_q == MODE_FLOW);
  assign flow_mode = (mode_q == MODE_FLOW);

  // Item decode.
  logic           idx_in_ops, mach_in_use, idx_in_max, mach_in_max;
  logic [OW-1:0]  in_op_idx;
  logic           do_assign, do_unassign, do_time, do_oper, do_job, do_prec;

  assign in_op_idx   = OW'(in_data_i.item_index);
  assign idx_in_ops  = 32'(in_data_i.item_index) < 32'(nops);
  assign mach_in_use = 32'(in_data_i.machine_number) < 32'(nmach);
  assign idx_in_max  = 32'(in_data_i.item_index) < 32'(MAX_OPERATIONS);
  assign mach_in_max = 32'(in_data_i.machine_number) < 32'(MAX_MACHINES);

  assign do_assign   = cmd_i.take && (in_data_i.op == OP_ASSIGN) && idx_in_ops && mach_in_use;
  assign do_unassign = cmd_i.take && (in_data_i.op == OP_UNASSIGN) && idx_in_ops;
  assign do_time     = cmd_i.take && (in_data_i.op == OP_LOAD_TIME) && idx_in_max && mach_in_max;
  assign do_oper     = cmd_i.take && (in_data_i.op == OP_LOAD_OPER) && idx_in_max;
  assign do_job      = cmd_i.take && (in_data_i.op == OP_LOAD_JOB) &&
                       (32'(in_data_i.item_index) < 32'(MAX_JOBS));
  assign do_prec     = cmd_i.take && (in_data_i.op == OP_LOAD_PREC) &&
                       (32'(in_data_i.item_index) < 32'(MAX_PRECEDENCES));

  // Assigned flags and count.
  logic [MAX_OPERATIONS-1:0] asg_q;
  logic [OCW-1:0]            acnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asg_q  <= '0;
      acnt_q <= '0;
    end else if (do_assign) begin
      asg_q[in_op_idx] <= 1'b1;
      if (!asg_q[in_op_idx]) begin
        acnt_q <= acnt_q + 1'b1;
      end
    end else if (do_unassign) begin
      asg_q[in_op_idx] <= 1'b0;
      if (asg_q[in_op_idx] && (acnt_q != '0)) begin
        acnt_q <= acnt_q - 1'b1;
      end
    end
  end

  // Walk counters.
  logic [CW-1:0] i_q;
  logic [KW-1:0] k_q;
  logic [OW-1:0] i_op;
  assign i_op = OW'(i_q);

  // Tables.
  slot_t slot_wr, slot_rd;
  len_t  len_wr, len_rd;
  logic  opt_rd;
  job_t  job_rd;
  prec_t prec_rd;
  info_t info_wr, info_a, info_b;
  logic [OW-1:0] info_a_addr, info_b_addr;
  logic [LW-1:0] len_waddr, len_raddr;

  assign slot_wr = '{mach: MW'(in_data_i.machine_number), start: in_data_i.time_value};
  assign len_wr  = '{elig: in_data_i.flag_bit, len: in_data_i.time_value};
  assign len_waddr = LW'(in_op_idx) * LW'(MAX_MACHINES) + LW'(in_data_i.machine_number);
  assign len_raddr = LW'(i_op) * LW'(MAX_MACHINES) + LW'(slot_rd.mach);

  sse_ram #(.WIDTH($bits(slot_t)), .DEPTH(MAX_OPERATIONS)) u_slot_ram (
    .clk_i, .we_i(do_assign), .waddr_i(in_op_idx), .wdata_i(slot_wr),
    .raddr_i(i_op), .rdata_o(slot_rd)
  );

  sse_ram #(.WIDTH($bits(len_t)), .DEPTH(LD)) u_len_ram (
    .clk_i, .we_i(do_time), .waddr_i(len_waddr), .wdata_i(len_wr),
    .raddr_i(len_raddr), .rdata_o(len_rd)
  );

  sse_ram #(.WIDTH(1), .DEPTH(MAX_OPERATIONS)) u_opt_ram (
    .clk_i, .we_i(do_oper), .waddr_i(in_op_idx), .wdata_i(in_data_i.flag_bit),
    .raddr_i(i_op), .rdata_o(opt_rd)
  );

  sse_ram #(.WIDTH($bits(job_t)), .DEPTH(MAX_JOBS)) u_job_ram (
    .clk_i, .we_i(do_job), .waddr_i(JW'(in_data_i.item_index)),
    .wdata_i({in_data_i.ref_first, in_data_i.flag_bit, in_data_i.time_value,
              in_data_i.job_weight_in}),
    .raddr_i(JW'(i_q)), .rdata_o(job_rd)
  );

  sse_ram #(.WIDTH($bits(prec_t)), .DEPTH(MAX_PRECEDENCES)) u_prec_ram (
    .clk_i, .we_i(do_prec), .waddr_i(PW'(in_data_i.item_index)),
    .wdata_i({in_data_i.ref_first, in_data_i.ref_second}),
    .raddr_i(PW'(i_q)), .rdata_o(prec_rd)
  );

  always_comb begin
    unique case (cmd_i.phase)
      PH_PAIR: begin
        info_a_addr = i_op;
        info_b_addr = OW'(k_q);
      end
      PH_PREC: begin
        info_a_addr = OW'(prec_rd.first);
        info_b_addr = OW'(prec_rd.second);
      end
      PH_JOB: begin
        info_a_addr = OW'(job_rd.last);
        info_b_addr = OW'(k_q);
      end
      default: begin
        info_a_addr = i_op;
        info_b_addr = OW'(k_q);
      end
    endcase
  end

  sse_ram #(.WIDTH($bits(info_t)), .DEPTH(MAX_OPERATIONS)) u_info_a_ram (
    .clk_i, .we_i(cmd_i.p1_chk), .waddr_i(i_op), .wdata_i(info_wr),
    .raddr_i(info_a_addr), .rdata_o(info_a)
  );

  sse_ram #(.WIDTH($bits(info_t)), .DEPTH(MAX_OPERATIONS)) u_info_b_ram (
    .clk_i, .we_i(cmd_i.p1_chk), .waddr_i(i_op), .wdata_i(info_wr),
    .raddr_i(info_b_addr), .rdata_o(info_b)
  );

  // First walk: per-operation completion and checks.
  logic        cur_asg;
  logic [31:0] cur_comp;
  logic        p1_bad;

  assign info_wr = '{start:   slot_rd.start,
                     mach:    slot_rd.mach,
                     comp:    17'(slot_rd.start) + 17'(len_rd.len),
                     inelig:  !len_rd.elig,
                     lenzero: len_rd.elig && (len_rd.len == 16'd0)};
  assign cur_asg  = asg_q[i_op];
  assign cur_comp = comp32(info_wr);
  assign p1_bad   = cur_asg ? (!len_rd.elig || (32'(slot_rd.mach) >= 32'(nmach))) : !opt_rd;

  // Pair walk.
  logic pair_bad;
  always_comb begin
    pair_bad = 1'b0;
    if (asg_q[i_op] && asg_q[OW'(k_q)] && (info_a.mach == info_b.mach)) begin
      if (info_a.start == info_b.start) begin
        pair_bad = !(info_a.lenzero && info_b.lenzero);
      end else if (info_a.start < info_b.start) begin
        pair_bad = comp32(info_a) > 32'(info_b.start);
      end else begin
        pair_bad = comp32(info_b) > 32'(info_a.start);
      end
    end
  end

  // Precedence walk.
  logic prec_bad;
  assign prec_bad = (32'(prec_rd.first) < 32'(nops)) && (32'(prec_rd.second) < 32'(nops)) &&
                    asg_q[OW'(prec_rd.first)] && asg_q[OW'(prec_rd.second)] &&
                    (comp32(info_a) > 32'(info_b.start));

  // Job walk.
  logic [31:0] job_c, tard_d;
  logic        skip_d;
  assign job_c  = job_rd.has_ops ? comp32(info_a) : 32'd0;
  assign skip_d = job_rd.has_ops &&
                  ((32'(job_rd.last) >= 32'(nops)) || !asg_q[OW'(job_rd.last)]);
  assign tard_d = flow_mode ? job_c :
                  ((job_c > 32'(job_rd.due)) ? job_c - 32'(job_rd.due) : 32'd0);

  logic [31:0] tard_q, mk_q, acc_q;
  logic        skip_q, feas_q;
  logic [39:0] term_q, prod;
  logic [31:0] term_sat;
  logic [32:0] acc_sum;

  assign prod     = 40'(tard_q) * 40'(job_rd.weight);
  assign term_sat = (term_q[39:32] != '0) ? 32'hFFFF_FFFF : term_q[31:0];
  assign acc_sum  = {1'b0, acc_q} + {1'b0, term_sat};

  always_ff @(posedge clk_i) begin
    if (cmd_i.p4_tard) begin
      tard_q <= tard_d;
      skip_q <= skip_d;
    end
    if (cmd_i.p4_mul) begin
      term_q <= flow_mode ? 40'(tard_q) : prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      k_q    <= '0;
      feas_q <= 1'b1;
      mk_q   <= '0;
      acc_q  <= '0;
    end else begin
      if (cmd_i.init) begin
        i_q    <= '0;
        feas_q <= 1'b1;
        mk_q   <= '0;
        acc_q  <= '0;
      end
      if (cmd_i.p1_chk) begin
        i_q <= i_q + 1'b1;
        if (p1_bad) begin
          feas_q <= 1'b0;
        end
        if (cur_asg && (cur_comp > mk_q)) begin
          mk_q <= cur_comp;
        end
      end
      if (cmd_i.p2_init) begin
        i_q <= '0;
        k_q <= KW'(1);
      end
      if (cmd_i.p2_chk) begin
        if (pair_bad) begin
          feas_q <= 1'b0;
        end
        if (32'(k_q) + 32'd1 >= 32'(nops)) begin
          i_q <= i_q + 1'b1;
          k_q <= KW'(i_q) + KW'(2);
        end else begin
          k_q <= k_q + 1'b1;
        end
      end
      if (cmd_i.p3_init || cmd_i.p4_init) begin
        i_q <= '0;
      end
      if (cmd_i.p3_chk) begin
        i_q <= i_q + 1'b1;
        if (prec_bad) begin
          feas_q <= 1'b0;
        end
      end
      if (cmd_i.p4_acc) begin
        i_q <= i_q + 1'b1;
        if (!skip_q) begin
          acc_q <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
        end
      end
    end
  end

  // Result register.
  logic      out_valid_q;
  out_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q.objective_value <= use_jobs ? acc_q : mk_q;
      out_data_q.is_feasible     <= feas_q;
      out_data_q.assigned_total  <= 7'(acnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign st_o.eval_op   = (in_data_i.op == OP_EVALUATE);
  assign st_o.op_done   = 32'(i_q) >= 32'(nops);
  assign st_o.pair_done = 32'(i_q) + 32'd1 >= 32'(nops);
  assign st_o.prec_done = 32'(i_q) >= 32'(nprec);
  assign st_o.job_done  = 32'(i_q) >= 32'(njobs);
  assign st_o.use_jobs  = use_jobs;
  assign st_o.out_busy  = out_valid_q;

endmodule

/* sv/schedule_solution_evaluator.sv */
// Load, assign and unassign beats return no result.
// An evaluate beat holds the input while the walks run, the job walk only for
// the sum objectives.
// Its result is registered from the done state; a result not yet taken adds its wait.
// One evaluation at a time; input stalls while it runs.
// Reset: asynchronous, active low; clears assignments and the count, and resets the configuration.
module schedule_solution_evaluator import sse_pkg::*; #(
  parameter int unsigned MAX_OPERATIONS  = SSE_MAX_OPERATIONS,
  parameter int unsigned MAX_MACHINES    = SSE_MAX_MACHINES,
  parameter int unsigned MAX_JOBS        = SSE_MAX_JOBS,
  parameter int unsigned MAX_PRECEDENCES = SSE_MAX_PRECEDENCES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // The controller sequences four walks over the tables: per-operation
  // completions and checks, operation pairs for overlap, precedence pairs,
  // and jobs for the sum objectives. The datapath owns every table and
  // accumulator; load beats write the tables directly.

  sse_cmd_t    cmd;
  sse_status_t st;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  sse_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .st_i  (st),
    .cmd_o (cmd)
  );

  sse_datapath #(
    .MAX_OPERATIONS  (MAX_OPERATIONS),
    .MAX_MACHINES    (MAX_MACHINES),
    .MAX_JOBS        (MAX_JOBS),
    .MAX_PRECEDENCES (MAX_PRECEDENCES)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .in_data_i,
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .cmd_i       (cmd),
    .st_o        (st),
    .out_stall_i,
    .out_valid_o,
    .out_data_o
  );

endmodule

/* sv/sse_checker.sv */
module sse_checker import sse_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // A waiting result stays until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // An accepted evaluate beat blocks the input while it runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.op == OP_EVALUATE) |=> in_stall_o)
    else $error("evaluate did not block the input");

  // A new result only follows an evaluation in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without evaluation");

endmodule

bind schedule_solution_evaluator sse_checker u_sse_checker (.*);

/* tb/tb_schedule_solution_evaluator.sv */
`timescale 1ns / 1ps

module tb_schedule_solution_evaluator;
  import sse_pkg::*;

  localparam longint unsigned SAT32 = 64'hFFFF_FFFF;
  localparam int NOPS = SSE_MAX_OPERATIONS;
  localparam int NMACH = SSE_MAX_MACHINES;
  localparam int NJOBS = SSE_MAX_JOBS;
  localparam int NPREC = SSE_MAX_PRECEDENCES;
  localparam logic [2:0] OP_RESERVED = 3'd7;
  localparam logic [1:0] MODE_MAKESPAN = 2'd0;

  // The scoreboard keeps its own copy of the schedule and the registers. Every
  // accepted input beat is applied to that copy, and an evaluate beat queues
  // the result that the block has to return.
  class sched_scoreboard;
    logic [1:0] mode;
    logic [6:0] ops_reg;
    logic [3:0] mach_reg;
    logic [5:0] jobs_reg;
    logic [6:0] prec_reg;
    logic [2:0] slot_mach[NOPS];
    logic [15:0] slot_start[NOPS];
    logic slot_used[NOPS];
    logic [15:0] proc_len[NOPS*NMACH];
    logic proc_ok[NOPS*NMACH];
    logic optional_op[NOPS];
    job_t jobs[NJOBS];
    prec_t precs[NPREC];
    logic [6:0] used_count;
    out_item_t eval_results_q[$];
    int errors;

    function void clear();
      mode = MODE_MAKESPAN;
      ops_reg = 0;
      mach_reg = 1;
      jobs_reg = 0;
      prec_reg = 0;
      used_count = 0;
      errors = 0;
      for (int i = 0; i < NOPS; i++) begin
        slot_mach[i] = 0;
        slot_start[i] = 0;
        slot_used[i] = 0;
        optional_op[i] = 0;
      end
    endfunction

    function int n_ops();
      return (ops_reg > NOPS) ? NOPS : ops_reg;
    endfunction

    function int n_mach();
      return (mach_reg > NMACH) ? NMACH : mach_reg;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_OBJECTIVE_MODE:   mode = val[1:0];
        CFG_OPERATION_COUNT:  ops_reg = val[6:0];
        CFG_MACHINE_COUNT:    mach_reg = val[3:0];
        CFG_JOB_COUNT:        jobs_reg = val[5:0];
        CFG_PRECEDENCE_COUNT: prec_reg = val[6:0];
        default: ;
      endcase
    endfunction

    function bit eligible(int o);
      return proc_ok[o*NMACH + slot_mach[o]];
    endfunction

    // An ineligible placement has a saturated length and completion.
    function longint unsigned op_len(int o);
      if (!eligible(o)) return SAT32;
      return proc_len[o*NMACH + slot_mach[o]];
    endfunction

    function longint unsigned finish_at(int o);
      if (!eligible(o)) return SAT32;
      return longint'(slot_start[o]) + op_len(o);
    endfunction

    function longint unsigned sat_sum(longint unsigned a, longint unsigned b);
      return (a + b > SAT32) ? SAT32 : a + b;
    endfunction

    function longint unsigned predict_objective();
      longint unsigned acc, c, t, term;
      int nj, last;
      acc = 0;
      nj = (jobs_reg > NJOBS) ? NJOBS : jobs_reg;
      if (mode == MODE_TARDINESS || mode == MODE_FLOW) begin
        for (int j = 0; j < nj; j++) begin
          if (!jobs[j].has_ops) c = 0;
          else begin
            last = jobs[j].last;
            if (last >= n_ops() || !slot_used[last]) continue;
            c = finish_at(last);
          end
          if (mode == MODE_FLOW) acc = sat_sum(acc, c);
          else begin
            t = (c > jobs[j].due) ? c - jobs[j].due : 0;
            term = t * jobs[j].weight;
            acc = sat_sum(acc, (term > SAT32) ? SAT32 : term);
          end
        end
      end else begin
        for (int i = 0; i < n_ops(); i++)
          if (slot_used[i] && finish_at(i) > acc) acc = finish_at(i);
      end
      return acc;
    endfunction

    function bit predict_feasible();
      int np, a, b;
      np = (prec_reg > NPREC) ? NPREC : prec_reg;
      for (int i = 0; i < n_ops(); i++) begin
        if (!slot_used[i]) begin
          if (!optional_op[i]) return 0;
        end else if (!eligible(i) || slot_mach[i] >= n_mach()) return 0;
      end
      for (int i = 0; i < n_ops(); i++) begin
        if (!slot_used[i]) continue;
        for (int k = i + 1; k < n_ops(); k++) begin
          if (!slot_used[k] || slot_mach[k] != slot_mach[i]) continue;
          // Equal starts collide unless both operations take no time.
          if (slot_start[i] == slot_start[k]) begin
            if (op_len(i) != 0 || op_len(k) != 0) return 0;
          end else if (slot_start[i] < slot_start[k]) begin
            if (finish_at(i) > slot_start[k]) return 0;
          end else if (finish_at(k) > slot_start[i]) return 0;
        end
      end
      for (int p = 0; p < np; p++) begin
        a = precs[p].first;
        b = precs[p].second;
        if (a >= n_ops() || b >= n_ops()) continue;
        if (!slot_used[a] || !slot_used[b]) continue;
        if (finish_at(a) > slot_start[b]) return 0;
      end
      return 1;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      int idx;
      idx = it.item_index;
      case (it.op)
        OP_ASSIGN: if (idx < n_ops() && it.machine_number < n_mach()) begin
          if (!slot_used[idx]) used_count++;
          slot_used[idx] = 1;
          slot_mach[idx] = it.machine_number;
          slot_start[idx] = it.time_value;
        end
        OP_UNASSIGN: if (idx < n_ops()) begin
          if (slot_used[idx] && used_count > 0) used_count--;
          slot_used[idx] = 0;
          slot_mach[idx] = 0;
          slot_start[idx] = 0;
        end
        OP_LOAD_TIME: begin
          proc_len[idx*NMACH + it.machine_number] = it.time_value;
          proc_ok[idx*NMACH + it.machine_number] = it.flag_bit;
        end
        OP_LOAD_OPER: optional_op[idx] = it.flag_bit;
        OP_LOAD_JOB: if (idx < NJOBS)
          jobs[idx] = '{last: it.ref_first, has_ops: it.flag_bit,
                        due: it.time_value, weight: it.job_weight_in};
        OP_LOAD_PREC: precs[idx] = '{first: it.ref_first, second: it.ref_second};
        OP_EVALUATE: begin
          r.objective_value = 32'(predict_objective());
          r.is_feasible = predict_feasible();
          r.assigned_total = used_count;
          eval_results_q = {eval_results_q, r};
        end
        default: ;
      endcase
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (eval_results_q.size() == 0) begin
        report("unexpected result beat", got, 0);
      end else begin
        want = eval_results_q.pop_front();
        if (got.objective_value !== want.objective_value)
          report("objective_value", got.objective_value, want.objective_value);
        if (got.is_feasible !== want.is_feasible)
          report("is_feasible", got.is_feasible, want.is_feasible);
        if (got.assigned_total !== want.assigned_total)
          report("assigned_total", got.assigned_total, want.assigned_total);
      end
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1;
  out_item_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sched_scoreboard sb;
  int results_seen = 0;
  int beats_sent = 0;
  bit pressure_done = 0;
  int machine_cursor[NMACH];

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  schedule_solution_evaluator u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Result monitor: values are sampled at the edge, before any update lands.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
      results_seen++;
    end
  end

  // Result receiver. Each beat is preceded by a random stall, often none. Once,
  // after some results, it holds off for a long stretch so the block backs up
  // and stalls the input side while the sender keeps offering beats.
  initial begin : result_receiver
    int gap;
    @(posedge rst_n);
    forever begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
      if (!pressure_done && results_seen >= 8) begin
        pressure_done = 1;
        gap = 400;
      end
      if (gap > 0) begin
        out_stall <= 1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one input beat after a random gap and returns once it is taken.
  task send_beat(in_item_t it);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    beats_sent++;
  endtask

  task send_fields(logic [2:0] op, int idx, int mach, int tval, int wt = 0,
                   bit flag = 0, int r1 = 0, int r2 = 0);
    in_item_t it;
    it.op = op;
    it.item_index = 6'(idx);
    it.machine_number = 3'(mach);
    it.time_value = 16'(tval);
    it.job_weight_in = 8'(wt);
    it.flag_bit = flag;
    it.ref_first = 6'(r1);
    it.ref_second = 6'(r2);
    send_beat(it);
  endtask

  // Registers are only written once every evaluation is back and any trailing
  // one-cycle beat has had time to finish.
  task drain();
    in_valid <= 0;
    while (sb.eval_results_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_reg(idx, CFG_DATA_W'(val));
  endtask

  task configure(int mode, int ops, int mach, int jobs, int precs);
    drain();
    write_reg(CFG_OBJECTIVE_MODE, mode);
    write_reg(CFG_OPERATION_COUNT, ops);
    write_reg(CFG_MACHINE_COUNT, mach);
    write_reg(CFG_JOB_COUNT, jobs);
    write_reg(CFG_PRECEDENCE_COUNT, precs);
  endtask

  task eval_all_modes();
    for (int m = 0; m < 4; m++) begin
      drain();
      write_reg(CFG_OBJECTIVE_MODE, m);
      send_fields(OP_EVALUATE, 0, 0, 0);
    end
  endtask

  // Fully random beat; index and times are biased toward the active range.
  task noise_beat();
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
    if ($urandom_range(0, 3) != 0)
      it.item_index = 6'($urandom_range(0, (sb.n_ops() > 0) ? sb.n_ops() - 1 : 0));
    if ($urandom_range(0, 1)) it.time_value = 16'($urandom_range(0, 60));
    send_beat(it);
  endtask

  // Builds a schedule on the active operations: each one gets a length, mostly
  // eligible, on a chosen machine and is packed behind the previous one there,
  // with the odd overlap, optional skip or shifted start mixed in.
  task build_schedule();
    int m, len, n;
    n = sb.n_ops();
    for (int k = 0; k < NMACH; k++) machine_cursor[k] = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      m = (sb.n_mach() > 0) ? $urandom_range(0, sb.n_mach() - 1) : 0;
      len = $urandom_range(0, 12);
      send_fields(OP_LOAD_TIME, i, m, len, 0, $urandom_range(0, 15) != 0);
      send_fields(OP_LOAD_OPER, i, 0, 0, 0, $urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) send_fields(OP_UNASSIGN, i, 0, 0);
      else begin
        send_fields(OP_ASSIGN, i, m, machine_cursor[m] - ($urandom_range(0, 12) == 0));
        machine_cursor[m] += len + $urandom_range(0, 3);
      end
    end
    for (int j = 0; j < 4; j++) begin
      send_fields(OP_LOAD_JOB, $urandom_range(0, NJOBS - 1), 0, $urandom_range(0, 80),
                  $urandom_range(0, 255), $urandom_range(0, 4) != 0,
                  $urandom_range(0, (n > 0) ? n - 1 : 0));
      send_fields(OP_LOAD_PREC, $urandom_range(0, NPREC - 1), 0, 0, 0, 0,
                  $urandom_range(0, (n > 0) ? n - 1 : 0),
                  $urandom_range(0, (n > 0) ? n - 1 : 0));
    end
  endtask

  initial begin : limit
    #(8 * 4_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int phase, ops, mach, n_beats;
    sb = new();
    sb.clear();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Fill the length, optional-flag, precedence and job tables before any evaluation reads them.
    for (int i = 0; i < NOPS; i++) begin
      for (int m = 0; m < NMACH; m++)
        send_fields(OP_LOAD_TIME, i, m, $urandom_range(0, 40), 0, $urandom_range(0, 1));
      send_fields(OP_LOAD_OPER, i, 0, 0, 0, $urandom_range(0, 1));
      send_fields(OP_LOAD_PREC, i, 0, 0, 0, 0, $urandom_range(0, 63), $urandom_range(0, 63));
    end
    for (int j = 0; j < NJOBS; j++)
      send_fields(OP_LOAD_JOB, j, 0, $urandom, $urandom, $urandom_range(0, 1), $urandom);

    // Directed part. Evaluate at reset counts first, then a small schedule with
    // the largest completion from the longest length and latest start.
    eval_all_modes();
    configure(MODE_MAKESPAN, 4, 2, 3, 2);
    send_fields(OP_LOAD_TIME, 0, 0, 16'hFFFF, 0, 1);
    send_fields(OP_LOAD_TIME, 1, 1, 0, 0, 1);
    send_fields(OP_LOAD_TIME, 2, 1, 0, 0, 1);
    send_fields(OP_LOAD_TIME, 3, 0, 5, 0, 0);
    send_fields(OP_LOAD_JOB, 0, 0, 0, 255, 1, 0);
    send_fields(OP_LOAD_JOB, 1, 0, 16'hFFFF, 1, 0, 63);
    send_fields(OP_LOAD_JOB, 2, 0, 3, 255, 1, 3);
    send_fields(OP_LOAD_PREC, 0, 0, 0, 0, 0, 1, 2);
    send_fields(OP_LOAD_PREC, 63, 0, 0, 0, 0, 63, 63);
    send_fields(OP_LOAD_OPER, 3, 0, 0, 0, 1);
    send_fields(OP_ASSIGN, 0, 0, 16'hFFFF);
    // Two zero-length operations with equal starts do not collide.
    send_fields(OP_ASSIGN, 1, 1, 7);
    send_fields(OP_ASSIGN, 2, 1, 7);
    send_fields(OP_ASSIGN, 63, 0, 0);
    send_fields(OP_ASSIGN, 1, 7, 0);
    send_fields(OP_RESERVED, 5, 7, 16'hFFFF, 255, 1, 63, 63);
    eval_all_modes();
    // An ineligible operation saturates, and unassign drops the count.
    send_fields(OP_ASSIGN, 3, 0, 0);
    send_fields(OP_UNASSIGN, 2, 0, 0);
    send_fields(OP_UNASSIGN, 63, 0, 0);
    eval_all_modes();

    // Random phases, with a couple at the largest sizes and clamped counts.
    phase = 0;
    while (beats_sent < 900) begin
      ops = (phase == 1 || phase == 3) ? $urandom_range(64, 127) : $urandom_range(0, 12);
      mach = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1)) ? 0 : $urandom_range(9, 15))
                                         : $urandom_range(1, 8);
      configure($urandom_range(0, 3), ops, mach, $urandom_range(0, 63), $urandom_range(0, 127));
      n_beats = (ops > 12) ? 10 : 30;
      if (ops <= 12 && $urandom_range(0, 3) != 0) begin
        build_schedule();
        send_fields(OP_EVALUATE, 0, 0, 0);
      end
      for (int b = 0; b < n_beats; b++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_fields(OP_EVALUATE, $urandom, $urandom, $urandom);
        end else noise_beat();
      end
      send_fields(OP_EVALUATE, 0, 0, 0);
      phase++;
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.eval_results_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
